### rtl/pmhd_pkg.sv
package pmhd_pkg;

  // Width of the incoming audio samples (two's complement).
  localparam int SampleBits = 16;
  // Width of peak * gain before scaling to Q0.16.
  localparam int ProdBits   = SampleBits + 16;
  // Snap threshold: 0.01 in Q0.16 is 655.36, floor taken.
  localparam logic [15:0] SnapExcess = 16'd655;

  localparam logic [15:0] InputGainRst   = 16'd256;
  localparam logic [15:0] DecayFactorRst = 16'd46334;
  localparam logic [7:0]  HoldTicksRst   = 8'd4;
  localparam logic        DecayEnableRst = 1'b1;

  typedef enum logic {
    OpSample = 1'b0,
    OpTick   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RegInputGain   = 2'd0,
    RegDecayFactor = 2'd1,
    RegHoldTicks   = 2'd2,
    RegDecayEnable = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] input_gain;
    logic [15:0] decay_factor;
    logic [7:0]  hold_ticks;
    logic        decay_enable;
  } cfg_t;

  typedef struct packed {
    logic [15:0]           shown_level;
    logic [15:0]           decay_target;
    logic [7:0]            hold_count;
    logic [SampleBits-1:0] block_peak;
  } meter_state_t;

endpackage

### rtl/pmhd_update.sv
module pmhd_update (
  input  pmhd_pkg::cfg_t                   cfg_i,
  input  pmhd_pkg::meter_state_t           state_i,
  input  pmhd_pkg::op_e                    op_i,
  input  logic [pmhd_pkg::SampleBits-1:0]  sample_i,
  input  logic                             last_i,
  output pmhd_pkg::meter_state_t           state_o
);

  logic [pmhd_pkg::SampleBits-1:0] mag;
  logic [pmhd_pkg::SampleBits-1:0] peak_new;
  logic [pmhd_pkg::ProdBits-1:0]   prod;
  logic [pmhd_pkg::ProdBits:0]     prod_x2;
  logic [pmhd_pkg::ProdBits:0]     scaled;
  logic [15:0]                     blk_val;
  logic [15:0]                     excess;
  logic [31:0]                     kept_prod;
  logic [15:0]                     kept;

  // Magnitude; most negative code maps to 2^(N-1), still fits unsigned N bits.
  assign mag      = sample_i[pmhd_pkg::SampleBits-1] ? (~sample_i + 1'b1) : sample_i;
  assign peak_new = (mag > state_i.block_peak) ? mag : state_i.block_peak;

  // Q(N-1) peak times Q8.8 gain, down to Q0.16: net shift right by N-9.
  assign prod    = pmhd_pkg::ProdBits'(peak_new) * pmhd_pkg::ProdBits'(cfg_i.input_gain);
  assign prod_x2 = {prod, 1'b0};
  assign scaled  = prod_x2 >> (pmhd_pkg::SampleBits - 8);
  assign blk_val = (|scaled[pmhd_pkg::ProdBits:16]) ? 16'hFFFF : scaled[15:0];

  // Decay step, only meaningful when shown > target.
  assign excess    = state_i.shown_level - state_i.decay_target;
  assign kept_prod = 32'(excess) * 32'(cfg_i.decay_factor);
  assign kept      = kept_prod[31:16];

  always_comb begin
    state_o = state_i;
    case (op_i)
      pmhd_pkg::OpSample: begin
        state_o.block_peak = peak_new;
        if (last_i) begin
          state_o.block_peak = '0;
          if (cfg_i.decay_enable) begin
            if (state_i.shown_level < blk_val) begin
              state_o.hold_count  = cfg_i.hold_ticks;
              state_o.shown_level = blk_val;
            end
            state_o.decay_target = blk_val;
          end else begin
            state_o.shown_level = blk_val;
          end
        end
      end
      pmhd_pkg::OpTick: begin
        if (cfg_i.decay_enable) begin
          if (state_i.hold_count != 8'd0) begin
            state_o.hold_count = state_i.hold_count - 8'd1;
          end else if (state_i.shown_level <= state_i.decay_target) begin
            state_o.shown_level = state_i.decay_target;
          end else if (kept > pmhd_pkg::SnapExcess) begin
            state_o.shown_level = state_i.decay_target + kept;
          end else begin
            state_o.shown_level = state_i.decay_target;
          end
        end
      end
      default: state_o = state_i;
    endcase
  end

endmodule

### rtl/peak_meter_hold_decay_core.sv
// Peak meter with hold and decay ballistics.
//
// Input channel (in_valid_i/in_ready_o): one beat is either an audio sample
// (op_i = 0, sample_i, last_i marks the final sample of a block) or a timer
// tick (op_i = 1). Every input beat yields exactly one output beat on
// out_valid_o/out_ready_i carrying the meter state after that beat: level_o,
// target_level_o and holding_o.
// A beat is captured in the input register on acceptance, and its result is
// then loaded into the result register, which drives out_valid_o. Throughput:
// one beat per cycle while out_ready_i is high; the meter state is computed
// combinationally between the two registers, so beats can follow back to back.
// Stall: when the receiver holds out_ready_i low, the result register keeps
// its beat and the input register still takes one more beat; after that
// in_ready_o drops until the output drains. No beat is lost or repeated.
// Reset (rst_ni low, async): meter state clears to zero, registers return
// to gain 1.0 (256), decay 0.707 (46334), hold 4 ticks, decay enabled.
// The APB port writes registers at byte offsets 0, 4, 8, 12 in that order;
// write only while the meter is idle.
module peak_meter_hold_decay_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic signed [pmhd_pkg::SampleBits-1:0] sample_i,
  input  logic                             last_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [15:0]                      level_o,
  output logic [15:0]                      target_level_o,
  output logic                             holding_o
);

  pmhd_pkg::cfg_t           cfg_q;
  pmhd_pkg::meter_state_t   state_q, state_d;
  pmhd_pkg::reg_idx_e       reg_idx;
  logic                     cfg_wr;

  // input register
  logic                              s1_valid_q;
  pmhd_pkg::op_e                     s1_op_q;
  logic [pmhd_pkg::SampleBits-1:0]   s1_sample_q;
  logic                              s1_last_q;

  // result register
  logic                              out_valid_q;
  logic [15:0]                       level_q;
  logic [15:0]                       target_q;
  logic                              holding_q;

  logic out_free;
  logic s1_adv;
  logic in_acc;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = pmhd_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_gain   <= pmhd_pkg::InputGainRst;
      cfg_q.decay_factor <= pmhd_pkg::DecayFactorRst;
      cfg_q.hold_ticks   <= pmhd_pkg::HoldTicksRst;
      cfg_q.decay_enable <= pmhd_pkg::DecayEnableRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        pmhd_pkg::RegInputGain:   cfg_q.input_gain   <= pwdata[15:0];
        pmhd_pkg::RegDecayFactor: cfg_q.decay_factor <= pwdata[15:0];
        pmhd_pkg::RegHoldTicks:   cfg_q.hold_ticks   <= pwdata[7:0];
        pmhd_pkg::RegDecayEnable: cfg_q.decay_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pmhd_pkg::RegInputGain:   prdata = {16'd0, cfg_q.input_gain};
      pmhd_pkg::RegDecayFactor: prdata = {16'd0, cfg_q.decay_factor};
      pmhd_pkg::RegHoldTicks:   prdata = {24'd0, cfg_q.hold_ticks};
      pmhd_pkg::RegDecayEnable: prdata = {31'd0, cfg_q.decay_enable};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: result reg frees when empty or taken; input reg moves on
  // whenever the result reg can take its beat.
  // ---------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= pmhd_pkg::op_e'(op_i);
      s1_sample_q <= sample_i;
      s1_last_q   <= last_i;
    end
  end

  // ---------------------------------------------------------------------
  // Meter state update: peak track, gain scale, hold/decay in one pass
  // ---------------------------------------------------------------------
  pmhd_update u_update (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .op_i     (s1_op_q),
    .sample_i (s1_sample_q),
    .last_i   (s1_last_q),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      level_q   <= state_d.shown_level;
      target_q  <= state_d.decay_target;
      holding_q <= (state_d.hold_count != 8'd0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_o        = level_q;
  assign target_level_o = target_q;
  assign holding_o      = holding_q;

endmodule

### dv/peak_meter_hold_decay_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both channels of the meter, keeps its own copy
// of the meter state and compares every output beat in order.
module peak_meter_hold_decay_checker
  import pmhd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  op_i,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  last_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [15:0]           level_i,
  input  logic [15:0]           target_level_i,
  input  logic                  holding_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] target;
    logic        holding;
  } meter_view_t;

  cfg_t         cfg;
  meter_state_t meter;
  meter_view_t  readings_q[$];
  int           fails;

  function automatic logic [SampleBits-1:0] magnitude(logic [SampleBits-1:0] raw);
    // most negative value maps to 2^(SampleBits-1), still fits unsigned
    return raw[SampleBits-1] ? (~raw + 1'b1) : raw;
  endfunction

  function automatic logic [15:0] block_level(logic [SampleBits-1:0] peak,
                                              logic [15:0] gain);
    logic [SampleBits+31:0] scaled;
    scaled = (({32'b0, peak} * gain) << 16) >> (SampleBits + 7);
    return (scaled > 65535) ? 16'hFFFF : scaled[15:0];
  endfunction

  function automatic logic [15:0] decayed(logic [15:0] shown, logic [15:0] target,
                                          logic [15:0] factor);
    logic [31:0] kept;
    kept = ({16'b0, shown - target} * {16'b0, factor}) >> 16;
    return (kept > SnapExcess) ? target + kept[15:0] : target;
  endfunction

  task automatic meter_step(logic op, logic [SampleBits-1:0] smp, logic lst);
    logic [15:0] val;
    meter_view_t view;
    if (op_e'(op) == OpTick) begin
      if (cfg.decay_enable) begin
        if (meter.hold_count != 0) begin
          meter.hold_count = meter.hold_count - 8'd1;
        end else if (meter.shown_level <= meter.decay_target) begin
          meter.shown_level = meter.decay_target;
        end else begin
          meter.shown_level = decayed(meter.shown_level, meter.decay_target,
                                      cfg.decay_factor);
        end
      end
    end else begin
      if (magnitude(smp) > meter.block_peak) meter.block_peak = magnitude(smp);
      if (lst) begin
        val = block_level(meter.block_peak, cfg.input_gain);
        if (cfg.decay_enable) begin
          if (meter.shown_level < val) begin
            meter.hold_count  = cfg.hold_ticks;
            meter.shown_level = val;
          end
          meter.decay_target = val;
        end else begin
          meter.shown_level = val;
        end
        meter.block_peak = '0;
      end
    end
    view.level   = meter.shown_level;
    view.target  = meter.decay_target;
    view.holding = (meter.hold_count != 0);
    readings_q.push_back(view);
  endtask

  function automatic int field_bad(string name, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    meter_view_t want;
    if (!rst_ni) begin
      cfg.input_gain   = InputGainRst;
      cfg.decay_factor = DecayFactorRst;
      cfg.hold_ticks   = HoldTicksRst;
      cfg.decay_enable = DecayEnableRst;
      meter            = '0;
      fails            = 0;
      readings_q.delete();
      fail_count_o    <= 0;
      pending_o       <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          RegInputGain:   cfg.input_gain   = pwdata[15:0];
          RegDecayFactor: cfg.decay_factor = pwdata[15:0];
          RegHoldTicks:   cfg.hold_ticks   = pwdata[7:0];
          RegDecayEnable: cfg.decay_enable = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (readings_q.size() == 0) begin
          $display("%0t: unexpected output beat, level %0d target %0d holding %0b",
                   $time, level_i, target_level_i, holding_i);
          fails++;
        end else begin
          want = readings_q.pop_front();
          if (field_bad("level", want.level, level_i) +
              field_bad("target_level", want.target, target_level_i) +
              field_bad("holding", want.holding, holding_i) != 0) fails++;
        end
      end
      if (in_valid_i && in_ready_i) meter_step(op_i, sample_i, last_i);
      fail_count_o <= fails;
      pending_o    <= readings_q.size();
    end
  end

endmodule

### dv/peak_meter_hold_decay_core_tb.sv
`timescale 1ns / 1ps

module peak_meter_hold_decay_core_tb;
  import pmhd_pkg::*;

  // quiet cycles (no beat on either channel) before the run is declared hung
  localparam int QuietLimit = 2000;
  // receiver hold-off used to back the meter up
  localparam int LongStall  = 300;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [3:0]                   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         op_i;
  logic signed [SampleBits-1:0] sample_i;
  logic                         last_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [15:0]                  level_o;
  logic [15:0]                  target_level_o;
  logic                         holding_o;

  int fail_count;
  int pending;
  int tx_idle_pct;   // chance, in percent, that the sender skips a cycle
  int rx_stall_pct;  // chance, in percent, that the receiver stalls a cycle
  int stall_req;     // bumped to ask the receiver for one long hold-off
  int quiet_cycles;

  peak_meter_hold_decay_core dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .sample_i,
    .last_i,
    .out_valid_o,
    .out_ready_i,
    .level_o,
    .target_level_o,
    .holding_o
  );

  // Prediction and comparison live in the checker; the top only drives.
  peak_meter_hold_decay_checker checker_i (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .op_i,
    .sample_i,
    .last_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .level_i        (level_o),
    .target_level_i (target_level_o),
    .holding_i      (holding_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Hang detector: any accepted beat on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no progress for %0d cycles", $time, QuietLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls per phase, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin
    int stall_seen;
    int stall_left;
    stall_seen  = 0;
    stall_left  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = LongStall;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // APB write: setup cycle, then access cycle; pready is tied high in the
  // block, so the register lands at the edge that closes the access cycle.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one beat and hold it until accepted. Valid is only dropped when
  // an idle gap is taken, so it never toggles within one time step.
  task automatic send_beat(op_e op, logic [SampleBits-1:0] smp, logic lst);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    sample_i   <= smp;
    last_i     <= lst;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Bring the meter to idle: wait out every pending result plus the input
  // and result register pipe before touching the registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sample values weighted toward the extremes and quiet passages so that
  // both louder and softer blocks turn up often.
  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return {1'b0, {(SampleBits-1){1'b1}}};
      1:       return {1'b1, {(SampleBits-1){1'b0}}};
      2:       return '0;
      3, 4:    return SampleBits'($signed($urandom_range(2000)) - 1000);
      default: return SampleBits'($urandom);
    endcase
  endfunction

  // Mostly well-formed traffic: audio blocks closed by a last sample, then
  // a run of ticks. A share of tick bursts and loose noise beats on top.
  task automatic run_stream(int n_items);
    int sent;
    int len;
    int kind;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_beat(OpSample, pick_sample(), i == len - 1);
        sent += len;
        len = $urandom_range(0, 8);
        repeat (len) send_beat(OpTick, SampleBits'($urandom), 1'($urandom_range(1)));
        sent += len;
      end else if (kind < 85) begin
        len = $urandom_range(1, 12);
        repeat (len) send_beat(OpTick, SampleBits'($urandom), 1'($urandom_range(1)));
        sent += len;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_beat(op_e'(1'($urandom_range(1))), pick_sample(),
                               1'($urandom_range(1)));
        sent += len;
      end
    end
  endtask

  initial begin
    logic [15:0] gain;
    logic [15:0] factor;
    logic [7:0]  hold;
    logic        enable;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    op_i         = OpSample;
    sample_i     = '0;
    last_i       = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    stall_req    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset config (gain 1.0, hold 4, decay on).
    // Block peak spans samples, with the peak not on the last one.
    send_beat(OpSample, 16'sd100, 1'b0);
    send_beat(OpSample, -16'sd200, 1'b0);
    send_beat(OpSample, 16'sd50, 1'b1);
    // Full scale positive, then most negative (counts as 1.0, saturates).
    send_beat(OpSample, 16'sh7FFF, 1'b1);
    send_beat(OpSample, 16'sh8000, 1'b1);
    // Silent block: target drops, shown level held.
    send_beat(OpSample, 16'sd0, 1'b1);
    // Hold countdown, then decay steps.
    repeat (10) send_beat(OpTick, 16'shA5A5, 1'b1);
    // Quieter block retargets without reloading the hold.
    send_beat(OpSample, 16'sd1000, 1'b1);
    // Decay steps toward the new target; the excess stays above the snap threshold.
    repeat (6) send_beat(OpTick, 16'sh5A5A, 1'b0);
    // Decay off: ticks ignored, level follows the block value.
    settle();
    write_reg(RegDecayEnable, 32'd0);
    send_beat(OpTick, 16'sd0, 1'b0);
    send_beat(OpSample, -16'sd5, 1'b1);

    // Random phases. Idle mode cycles: none, sender idle, receiver
    // stalling, both lightly. Fixed configs, extremes among them, mixed with random ones.
    for (int ph = 0; ph < 9; ph++) begin
      settle();
      case (ph)
        0: begin gain = 16'd256;   factor = 16'd46334; hold = 8'd4;   enable = 1'b1; end
        1: begin gain = 16'hFFFF;  factor = 16'hFFFF;  hold = 8'd0;   enable = 1'b1; end
        2: begin gain = 16'd0;     factor = 16'd0;     hold = 8'hFF;  enable = 1'b1; end
        4: begin gain = 16'd128;   factor = 16'd60000; hold = 8'd2;   enable = 1'b1; end
        6: begin gain = 16'd1024;  factor = 16'd30000; hold = 8'd8;   enable = 1'b1; end
        8: begin gain = 16'd512;   factor = 16'd0;     hold = 8'd0;   enable = 1'b1; end
        default: begin
          gain   = 16'($urandom_range(1023));
          factor = 16'($urandom);
          hold   = 8'($urandom_range(15));
          enable = (ph == 3) ? 1'b0 : (ph == 5) ? 1'b1 : 1'($urandom_range(1));
        end
      endcase
      write_reg(RegInputGain, {16'b0, gain});
      write_reg(RegDecayFactor, {16'b0, factor});
      write_reg(RegHoldTicks, {24'b0, hold});
      write_reg(RegDecayEnable, {31'b0, enable});
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct = 68; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct <= 68; end
        default: begin tx_idle_pct = 11; rx_stall_pct <= 11; end
      endcase
      // Back-pressure: receiver holds off while the sender keeps offering.
      if (ph == 4) stall_req <= stall_req + 1;
      run_stream(78);
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/pmhd_pkg.sv
rtl/pmhd_update.sv
rtl/peak_meter_hold_decay_core.sv
dv/peak_meter_hold_decay_checker.sv
dv/peak_meter_hold_decay_core_tb.sv
